FILE: rtl/core/b62ts_pkg.sv
// ----------------------------------------------------------------------------
// b62ts_pkg
// Shared widths, radix constants and the base-62 character table for the
// base-62 time stamp encoder.
// ----------------------------------------------------------------------------
package b62ts_pkg;

  // Field widths
  localparam int unsigned TS_W    = 55;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 6;

  // Work value and divide chunking
  localparam int unsigned WORK_W      = 72;
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned N_CHUNKS    = WORK_W / CHUNK_W;
  localparam int unsigned CHUNK_CNT_W = $clog2(N_CHUNKS);

  // Radix and default digit count
  localparam int unsigned RADIX      = 62;
  localparam int unsigned DIGITS_DEF = 12;

  // Digit to ASCII: 0-9, A-Z, a-z; codes past the alphabet give '0'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d);
    case (d) inside
      [6'd0:6'd9]:   digit_to_ascii = c + CHAR_W'(48);
      [6'd10:6'd35]: digit_to_ascii = c + CHAR_W'(55);
      [6'd36:6'd61]: digit_to_ascii = c + CHAR_W'(61);
      default:       digit_to_ascii = CHAR_W'(48);
    endcase
  endfunction

endpackage

FILE: rtl/core/b62ts_div8.sv
// ----------------------------------------------------------------------------
// b62ts_div8
// Shared divide unit: eight restoring steps of division by 62 on one byte of
// the work value, carrying the partial remainder from the previous byte.
// ----------------------------------------------------------------------------
module b62ts_div8
  import b62ts_pkg::*;
(
  input  logic [DIGIT_W-1:0] rem_i,
  input  logic [CHUNK_W-1:0] byte_i,
  output logic [CHUNK_W-1:0] quot_o,
  output logic [DIGIT_W-1:0] rem_o
);

  localparam logic [DIGIT_W:0] RadixW = (DIGIT_W+1)'(RADIX);

  logic [DIGIT_W:0]   part;
  logic [DIGIT_W:0]   trial;
  logic [CHUNK_W-1:0] quot;

  // Restoring divide, msb first; partial remainder stays below the radix
  always_comb begin
    part = {1'b0, rem_i};
    quot = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      trial = {part[DIGIT_W-1:0], byte_i[i]};
      if (trial >= RadixW) begin
        trial   = trial - RadixW;
        quot[i] = 1'b1;
      end
      part = trial;
    end
  end

  assign quot_o = quot;
  assign rem_o  = part[DIGIT_W-1:0];

endmodule

FILE: rtl/core/base62_time_stamp_encoder_core.sv
// ----------------------------------------------------------------------------
// base62_time_stamp_encoder_core
// Packs a millisecond time stamp with a rolling 16-bit sequence number and
// emits the 72-bit value as DIGITS base-62 ASCII characters, msd first.
// ----------------------------------------------------------------------------
// Flow: an input beat starts the divide passes, one per digit, lsd first,
//   each feeding one byte of the work value through the shared divide unit
//   per cycle, nine bytes per digit; then one character per cycle while
//   out_ready_i. A new stamp is taken only once the last character is loaded;
//   in_ready_o is high only while the sequencer is idle.
// Reset: rst_ni clears the sequencer, sequence number and output valid.
// ----------------------------------------------------------------------------
module base62_time_stamp_encoder_core
  import b62ts_pkg::*;
#(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [TS_W-1:0]   timestamp_ms_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] stamp_char_o,
  output logic              last_char_o
);

  localparam int unsigned IDX_W = $clog2(DIGITS);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DIGITS - 1);
  localparam logic [CHUNK_CNT_W-1:0] LastChunk = CHUNK_CNT_W'(N_CHUNKS - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [SEQ_W-1:0]       seq_q, seq_d;
  logic [WORK_W-1:0]      work_q, work_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [CHUNK_CNT_W-1:0] chunk_q, chunk_d;
  logic [IDX_W-1:0]       digit_q, digit_d;
  logic [DIGIT_W-1:0]     digit_store_q [DIGITS];
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q, last_d;

  logic                   in_beat;
  logic                   out_load;
  logic                   store_wr;
  logic [CHUNK_W-1:0]     quot_byte;
  logic [DIGIT_W-1:0]     rem_next;

  assign in_beat = in_valid_i && (state_q == ST_IDLE);

  // Shared divide unit on the top byte of the work value
  b62ts_div8 u_div (
    .rem_i  (rem_q),
    .byte_i (work_q[WORK_W-1 -: CHUNK_W]),
    .quot_o (quot_byte),
    .rem_o  (rem_next)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    seq_d       = seq_q;
    work_d      = work_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    digit_d     = digit_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    out_load    = 1'b0;
    store_wr    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          work_d  = {1'b0, timestamp_ms_i, seq_q};
          seq_d   = seq_q + SEQ_W'(1);
          rem_d   = '0;
          chunk_d = '0;
          digit_d = LastIdx;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // quotient bytes rotate in at the bottom as dividend bytes leave
        work_d = {work_q[WORK_W-CHUNK_W-1:0], quot_byte};
        if (chunk_q == LastChunk) begin
          store_wr = 1'b1;
          rem_d    = '0;
          chunk_d  = '0;
          if (digit_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            digit_d = digit_q - IDX_W'(1);
          end
        end else begin
          rem_d   = rem_next;
          chunk_d = chunk_q + CHUNK_CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          last_d      = (digit_q == LastIdx);
          if (digit_q == LastIdx) begin
            digit_d = '0;
            state_d = ST_IDLE;
          end else begin
            digit_d = digit_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seq_q       <= '0;
      rem_q       <= '0;
      chunk_q     <= '0;
      digit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      rem_q       <= rem_d;
      chunk_q     <= chunk_d;
      digit_q     <= digit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; the character is read from the digit store here
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (out_load) begin
      char_q <= digit_to_ascii(digit_store_q[digit_q]);
      last_q <= last_d;
    end
  end

  // Digit store, written once per digit at the end of its divide pass
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      digit_store_q[digit_q] <= rem_next;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign stamp_char_o = char_q;
  assign last_char_o  = last_q;

  // Checks
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DIV)
    else $error("input beat did not start a divide pass");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < DIGIT_W'(RADIX))
    else $error("partial remainder reached the radix");

  a_store_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> digit_store_q[digit_q] < DIGIT_W'(RADIX))
    else $error("stored digit out of range");

  // a waiting last character holds off the next stamp's first one
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o && state_q == ST_EMIT |-> digit_q == '0)
    else $error("next stamp emitted before the last character left");

endmodule
